// ===== rtl/core/pid_pkg.sv =====
// shared constants, codes and types of the priority interrupt dispatch block
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

  // line and lane geometry
  localparam int NUM_LINES  = 64;
  localparam int CODE_BITS  = 4;
  localparam int LANE_LINES = 16;
  localparam int NUM_LANES  = 4;
  localparam int IDX_W      = $clog2(LANE_LINES);
  localparam int LANE_W     = $clog2(NUM_LANES);
  localparam int LINE_W     = 6;
  localparam int WORD_W     = LANE_LINES * CODE_BITS;
  localparam int IRQ_W      = 7;
  localparam int CNT_W      = 32;
  localparam int LEVEL_W    = 4;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ASSIGN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORDS      = 3'd4;

  // core levels
  localparam logic [LEVEL_W-1:0] TIMER_LEVEL      = 4'd6;
  localparam logic [LEVEL_W-1:0] FIRST_PERI_LEVEL = 4'd7;
  localparam logic [LEVEL_W-1:0] LAST_PERI_LEVEL  = 4'd13;

  // operation codes
  localparam logic [1:0] OP_DISPATCH = 2'd0;
  localparam logic [1:0] OP_MASK     = 2'd1;
  localparam logic [1:0] OP_UNMASK   = 2'd2;

  // request kinds held between lane and merge stages
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_TIMER = 2'd1;
  localparam logic [1:0] KIND_PERI  = 2'd2;

  // what one lane found
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } lane_res_t;

  // merged dispatch answer
  typedef struct packed {
    logic             hit;
    logic [IRQ_W-1:0] irq;
  } disp_t;

endpackage

`default_nettype wire

// ===== rtl/core/priority_interrupt_dispatch.sv =====
// top level of the priority interrupt dispatch block
// a dispatch word taken on the input goes through the lane compare register,
// then through the merge stage into the output register, and shows on out_tvalid
// throughput: one word per cycle while out_tready stays high; mask and unmask
// words give no result
// reset: synchronous, clears level codes, line mask, spurious count and valids
`timescale 1ns / 1ps
`default_nettype none

module priority_interrupt_dispatch (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // core_level[3:0], peripheral_line[9:4], pending_flags[73:10]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // irq_number[6:0], spurious_total[38:7]
  output logic [0:0]       out_tuser,  // found[0]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [pid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
  import pid_pkg::*;

  // unpacked input word
  logic [1:0]           op;
  logic [LEVEL_W-1:0]   lvl;
  logic [LINE_W-1:0]    pline;
  logic [NUM_LINES-1:0] pending;

  assign op      = in_tuser;
  assign lvl     = in_tdata[3:0];
  assign pline   = in_tdata[9:4];
  assign pending = in_tdata[73:10];

  // state
  logic [WORD_W-1:0]    level_r [NUM_LANES];
  logic [NUM_LINES-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]     spur_r, spur_nxt;

  logic                             s1_valid_r, s1_valid_nxt;
  logic [1:0]                       s1_kind_r;
  lane_res_t [NUM_LANES-1:0]        s1_lane_r;

  logic             out_valid_r, out_valid_nxt;
  logic [IRQ_W-1:0] out_irq_r;
  logic             out_found_r;
  logic [CNT_W-1:0] out_spur_r;

  // handshakes
  logic in_acc, s1_adv, disp_acc, cfg_acc;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign disp_acc  = in_acc && (op == OP_DISPATCH);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // line valid vector: every line is set to qualify
  logic [NUM_LINES-1:0] line_ok;
  always_comb begin
    for (int i = 0; i < NUM_LINES; i++) begin
      line_ok[i] = 1'b1;
    end
  end

  // level classification and lane inputs
  logic [1:0]           kind_in;
  logic [CODE_BITS-1:0] want;
  logic [NUM_LINES-1:0] live;

  always_comb begin
    if (lvl == TIMER_LEVEL) begin
      kind_in = KIND_TIMER;
    end else if (lvl inside {[FIRST_PERI_LEVEL:LAST_PERI_LEVEL]}) begin
      kind_in = KIND_PERI;
    end else begin
      kind_in = KIND_NONE;
    end
  end

  assign want = CODE_BITS'(lvl - FIRST_PERI_LEVEL);
  assign live = pending & mask_r & line_ok;

  // search lanes
  lane_res_t [NUM_LANES-1:0] lane_res;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    pid_lane u_lane (
      .code_word (level_r[l]),
      .live      (live[l*LANE_LINES +: LANE_LINES]),
      .want      (want),
      .res       (lane_res[l])
    );
  end

  // merge stage
  disp_t disp;

  pid_merge u_merge (
    .kind  (s1_kind_r),
    .lanes (s1_lane_r),
    .disp  (disp)
  );

  // mask update on mask and unmask words
  always_comb begin
    mask_nxt = mask_r;
    if (in_acc && ({1'b0, pline} < 7'(NUM_LINES))) begin
      if (op == OP_MASK) begin
        mask_nxt[pline] = 1'b0;
      end else if (op == OP_UNMASK) begin
        mask_nxt[pline] = 1'b1;
      end
    end
  end

  // spurious count and valid flags
  always_comb begin
    spur_nxt = spur_r;
    if (s1_adv && !disp.hit) begin
      spur_nxt = spur_r + CNT_W'(1);
    end
    if (disp_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      spur_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
        level_r[l] <= '0;
      end
    end else begin
      mask_r      <= mask_nxt;
      spur_r      <= spur_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_acc && (cfg_index < CFG_NUM_WORDS)) begin
        level_r[LANE_W'(cfg_index - CFG_LEVEL_ASSIGN_0)] <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (disp_acc) begin
      s1_kind_r <= kind_in;
      s1_lane_r <= lane_res;
    end
    if (s1_adv) begin
      out_irq_r   <= disp.irq;
      out_found_r <= disp.hit;
      out_spur_r  <= spur_nxt;
    end
  end

  // output word
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_spur_r, out_irq_r};
  assign out_tuser  = out_found_r;

  // checks
  a_found_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[6:0] >= 7'd6)
    else $error("found result with irq below timer level");

  a_spur_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[6:0] == 7'd0)
    else $error("spurious result with nonzero irq");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !disp.hit |=> spur_r == $past(spur_r) + 32'd1)
    else $error("spurious count did not step by one");

  a_disp_held: assert property (@(posedge clk) disable iff (!rst_n)
    disp_acc |=> s1_valid_r)
    else $error("taken dispatch word not held in lane stage");

endmodule

`default_nettype wire

// ===== rtl/core/pid_lane.sv =====
// one search lane: lowest live line of its group whose level code matches
`timescale 1ns / 1ps
`default_nettype none

module pid_lane (
  input  wire logic [pid_pkg::WORD_W-1:0]     code_word,
  input  wire logic [pid_pkg::LANE_LINES-1:0] live,
  input  wire logic [pid_pkg::CODE_BITS-1:0]  want,
  output pid_pkg::lane_res_t                  res
);
  import pid_pkg::*;

  // priority search, lowest line wins
  always_comb begin
    res.hit = 1'b0;
    res.idx = '0;
    for (int i = LANE_LINES - 1; i >= 0; i--) begin
      if (live[i] && (code_word[i*CODE_BITS +: CODE_BITS] == want)) begin
        res.hit = 1'b1;
        res.idx = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pid_merge.sv =====
// merge stage: picks the lowest lane with a hit and forms the irq number
`timescale 1ns / 1ps
`default_nettype none

module pid_merge (
  input  wire logic [1:0]                              kind,
  input  wire pid_pkg::lane_res_t [pid_pkg::NUM_LANES-1:0] lanes,
  output pid_pkg::disp_t                               disp
);
  import pid_pkg::*;

  logic              any_hit;
  logic [LANE_W-1:0] lane_sel;
  logic [IDX_W-1:0]  idx_sel;

  // lowest lane that found a line
  always_comb begin
    any_hit  = 1'b0;
    lane_sel = '0;
    idx_sel  = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (lanes[l].hit) begin
        any_hit  = 1'b1;
        lane_sel = LANE_W'(l);
        idx_sel  = lanes[l].idx;
      end
    end
  end

  // irq number by request kind
  always_comb begin
    disp.hit = 1'b0;
    disp.irq = '0;
    case (kind)
      KIND_TIMER: begin
        disp.hit = 1'b1;
        disp.irq = IRQ_W'(TIMER_LEVEL);
      end
      KIND_PERI: begin
        if (any_hit) begin
          disp.hit = 1'b1;
          disp.irq = IRQ_W'(FIRST_PERI_LEVEL) + IRQ_W'({lane_sel, idx_sel});
        end
      end
      default: begin
        disp.hit = 1'b0;
        disp.irq = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
